@@ rtl/nle_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and codes for the normalized legendre evaluator
package nle_pkg;

    localparam int FRAC_BITS  = 30;
    localparam int MAX_DEGREE = 63;
    localparam int DVD_W      = 96;
    localparam int SQ_STEPS   = DVD_W / 2;
    localparam int MUL_STEPS  = 4;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [39:0] OUT_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] OUT_MIN = {1'b1, {39{1'b0}}};

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [5:0]        degree;
        logic [5:0]        order;
        logic signed [31:0] x_value;
    } req_word_t;

    typedef struct packed {
        logic signed [39:0] result_value;
        logic [1:0]         status;
    } rsp_word_t;

    typedef enum logic [2:0] {
        AOP_QMUL,
        AOP_IMUL,
        AOP_QDIV,
        AOP_IDIV,
        AOP_ROOT
    } au_op_t;

    typedef struct packed {
        logic               start;
        au_op_t             op;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         sh;
    } au_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] result;
    } au_rsp_t;

    typedef enum logic [2:0] {
        AU_IDLE,
        AU_MUL,
        AU_MFIN,
        AU_DIV,
        AU_DFIN,
        AU_SQRT,
        AU_DONE
    } au_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_OMX,
        S_SEED_M,
        S_SEED_I,
        S_SEED_D,
        S_SEED_N,
        S_SEED_R,
        S_PREV,
        S_P1A,
        S_P1B,
        S_FCT,
        S_XP,
        S_QD,
        S_PK,
        S_LFIN,
        S_CO,
        S_CO2,
        S_XN,
        S_DA,
        S_DB,
        S_DEN,
        S_DDIV,
        S_END,
        S_ENDM,
        S_FIN
    } nle_state_t;

endpackage

@@ rtl/normalized_legendre_evaluator_unit.sv @@
`timescale 1ns / 1ps
// top level: sequencer for normalized associated legendre values and derivatives
// the shared unit divides one quotient bit per cycle; a root of a ratio runs a divide and then a root
// value mode runs the seed product over m, then the recurrence up to degree n; a derivative runs
//   the value at degree n and n+1, then the derivative terms; an endpoint derivative uses a closed form
// throughput: one word at a time, ready only while idle; a finished word waits in the
//   output register while the next word is taken
// reset: rst_n clears the sequencer, the shared unit and the output valid at once
module normalized_legendre_evaluator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  nle_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output nle_pkg::rsp_word_t rsp
);

    localparam logic signed [31:0] X_ONE = 32'(nle_pkg::ONE);

    nle_pkg::nle_state_t state_reg, state_next;
    logic               issued_reg;
    logic               phase_reg;
    logic               cmd_reg;
    logic [5:0]         deg_reg;
    logic [6:0]         n_reg;
    logic [5:0]         m_reg;
    logic [6:0]         k_reg;
    logic               xneg_end_reg;
    logic signed [31:0] x_reg;
    logic signed [63:0] omx_reg, pmm_reg, p1_reg, prev_reg, fct_reg;
    logic signed [63:0] tmp_reg, tmp2_reg, pn_reg, res_reg;
    logic [1:0]         status_reg;
    logic               out_valid_reg;
    nle_pkg::rsp_word_t out_word_reg;

    nle_pkg::au_req_t au_req;
    nle_pkg::au_rsp_t au_rsp;
    logic             au_use;
    logic             done;

    logic signed [31:0] x_clamped;
    logic               x_edge;
    logic               out_free;
    logic signed [63:0] x64;
    logic [13:0]        k_sq;
    logic [11:0]        m_sq;
    logic [15:0]        fct_num;
    logic [13:0]        fct_den;
    logic [7:0]         m_plus2;
    logic [10:0]        tri_n;
    logic signed [63:0] den_val;
    logic signed [63:0] seed_root;

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b);
        if (d > 65'(nle_pkg::LIM))
            return nle_pkg::LIM;
        else if (d < -65'(nle_pkg::LIM))
            return -nle_pkg::LIM;
        else
            return 64'(d);
    endfunction

    nle_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (au_req),
        .rsp   (au_rsp)
    );

    assign done = au_rsp.done;

    // x clamped to [-1,1] on the way in
    always_comb
    begin
        if (req.x_value > X_ONE)
            x_clamped = X_ONE;
        else if (req.x_value < -X_ONE)
            x_clamped = -X_ONE;
        else
            x_clamped = req.x_value;
        x_edge = (x_clamped == X_ONE) || (x_clamped == -X_ONE);
    end

    // small index arithmetic for the recurrence coefficients
    always_comb
    begin
        x64       = 64'(x_reg);
        k_sq      = 14'(k_reg) * 14'(k_reg);
        m_sq      = 12'(m_reg) * 12'(m_reg);
        fct_num   = {k_sq, 2'b00} - 16'd1;
        fct_den   = k_sq - 14'(m_sq);
        m_plus2   = {2'b00, m_reg} + 8'd2;
        tri_n     = 11'((12'(deg_reg) * (12'(deg_reg) + 12'd1)) >> 1);
        den_val   = nle_pkg::ONE - au_rsp.result;
        seed_root = m_reg[0] ? -au_rsp.result : au_rsp.result;
        out_free  = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nle_pkg::S_IDLE:
                if (req_valid)
                begin
                    if (req.cmd && x_edge)
                        state_next = nle_pkg::S_END;
                    else if (!req.cmd && req.order > req.degree)
                        state_next = nle_pkg::S_FIN;
                    else
                        state_next = nle_pkg::S_OMX;
                end
            nle_pkg::S_OMX:
                if (done)
                    state_next = (m_reg != 6'd0) ? nle_pkg::S_SEED_M : nle_pkg::S_SEED_N;
            nle_pkg::S_SEED_M: if (done) state_next = nle_pkg::S_SEED_I;
            nle_pkg::S_SEED_I: if (done) state_next = nle_pkg::S_SEED_D;
            nle_pkg::S_SEED_D:
                if (done)
                    state_next = (k_reg == {1'b0, m_reg}) ? nle_pkg::S_SEED_N
                                                          : nle_pkg::S_SEED_M;
            nle_pkg::S_SEED_N: if (done) state_next = nle_pkg::S_SEED_R;
            nle_pkg::S_SEED_R:
                if (done)
                    state_next = (n_reg == {1'b0, m_reg}) ? nle_pkg::S_LFIN
                                                          : nle_pkg::S_PREV;
            nle_pkg::S_PREV: if (done) state_next = nle_pkg::S_P1A;
            nle_pkg::S_P1A:  if (done) state_next = nle_pkg::S_P1B;
            nle_pkg::S_P1B:
                if (done)
                    state_next = (m_plus2 > {1'b0, n_reg}) ? nle_pkg::S_LFIN
                                                           : nle_pkg::S_FCT;
            nle_pkg::S_FCT: if (done) state_next = nle_pkg::S_XP;
            nle_pkg::S_XP:  if (done) state_next = nle_pkg::S_QD;
            nle_pkg::S_QD:  if (done) state_next = nle_pkg::S_PK;
            nle_pkg::S_PK:
                if (done)
                    state_next = (k_reg == n_reg) ? nle_pkg::S_LFIN : nle_pkg::S_FCT;
            nle_pkg::S_LFIN:
                if (!cmd_reg)
                    state_next = nle_pkg::S_FIN;
                else if (!phase_reg)
                    state_next = nle_pkg::S_OMX;
                else
                    state_next = nle_pkg::S_CO;
            nle_pkg::S_CO:   if (done) state_next = nle_pkg::S_CO2;
            nle_pkg::S_CO2:  if (done) state_next = nle_pkg::S_XN;
            nle_pkg::S_XN:   if (done) state_next = nle_pkg::S_DA;
            nle_pkg::S_DA:   if (done) state_next = nle_pkg::S_DB;
            nle_pkg::S_DB:   if (done) state_next = nle_pkg::S_DEN;
            nle_pkg::S_DEN:  if (done) state_next = nle_pkg::S_DDIV;
            nle_pkg::S_DDIV: if (done) state_next = nle_pkg::S_FIN;
            nle_pkg::S_END:  if (done) state_next = nle_pkg::S_ENDM;
            nle_pkg::S_ENDM: if (done) state_next = nle_pkg::S_FIN;
            nle_pkg::S_FIN:
                if (out_free)
                    state_next = nle_pkg::S_IDLE;
            default:
                state_next = nle_pkg::S_IDLE;
        endcase
    end

    // operation issued to the shared unit in each state that uses it
    always_comb
    begin
        au_use    = 1'b1;
        au_req.op = nle_pkg::AOP_QMUL;
        au_req.a  = '0;
        au_req.b  = '0;
        au_req.sh = '0;
        case (state_reg)
            nle_pkg::S_OMX, nle_pkg::S_DEN:
            begin
                au_req.a = x64;
                au_req.b = x64;
            end
            nle_pkg::S_SEED_M:
            begin
                au_req.a = pmm_reg;
                au_req.b = omx_reg;
            end
            nle_pkg::S_SEED_I:
            begin
                au_req.op = nle_pkg::AOP_IMUL;
                au_req.a  = pmm_reg;
                au_req.b  = 64'({k_reg, 1'b0} - 8'd1);
            end
            nle_pkg::S_SEED_D:
            begin
                au_req.op = nle_pkg::AOP_IDIV;
                au_req.a  = pmm_reg;
                au_req.b  = 64'({k_reg, 1'b0});
            end
            nle_pkg::S_SEED_N:
            begin
                au_req.op = nle_pkg::AOP_IMUL;
                au_req.a  = pmm_reg;
                au_req.b  = 64'({m_reg, 1'b1});
            end
            nle_pkg::S_SEED_R:
            begin
                au_req.op = nle_pkg::AOP_ROOT;
                au_req.a  = tmp_reg;
                au_req.b  = 64'sd2;
                au_req.sh = 6'(nle_pkg::FRAC_BITS);
            end
            nle_pkg::S_PREV:
            begin
                au_req.op = nle_pkg::AOP_ROOT;
                au_req.a  = 64'({1'b0, m_reg, 1'b1} + 8'd2);
                au_req.b  = 64'sd1;
                au_req.sh = 6'(2 * nle_pkg::FRAC_BITS);
            end
            nle_pkg::S_P1A:
            begin
                au_req.a = x64;
                au_req.b = prev_reg;
            end
            nle_pkg::S_P1B:
            begin
                au_req.a = tmp_reg;
                au_req.b = pmm_reg;
            end
            nle_pkg::S_FCT:
            begin
                au_req.op = nle_pkg::AOP_ROOT;
                au_req.a  = 64'(fct_num);
                au_req.b  = 64'(fct_den);
                au_req.sh = 6'(2 * nle_pkg::FRAC_BITS);
            end
            nle_pkg::S_XP:
            begin
                au_req.a = x64;
                au_req.b = p1_reg;
            end
            nle_pkg::S_QD:
            begin
                au_req.op = nle_pkg::AOP_QDIV;
                au_req.a  = pmm_reg;
                au_req.b  = prev_reg;
            end
            nle_pkg::S_PK:
            begin
                au_req.a = tmp2_reg;
                au_req.b = fct_reg;
            end
            nle_pkg::S_CO:
            begin
                au_req.op = nle_pkg::AOP_ROOT;
                au_req.a  = 64'({deg_reg, 1'b1});
                au_req.b  = 64'({1'b0, deg_reg, 1'b1} + 8'd2);
                au_req.sh = 6'(2 * nle_pkg::FRAC_BITS);
            end
            nle_pkg::S_CO2:
            begin
                au_req.op = nle_pkg::AOP_IMUL;
                au_req.a  = tmp_reg;
                au_req.b  = 64'({1'b0, deg_reg} + 7'd1);
            end
            nle_pkg::S_XN:
            begin
                au_req.op = nle_pkg::AOP_IMUL;
                au_req.a  = x64;
                au_req.b  = 64'({1'b0, deg_reg} + 7'd1);
            end
            nle_pkg::S_DA:
            begin
                au_req.a = tmp_reg;
                au_req.b = pn_reg;
            end
            nle_pkg::S_DB:
            begin
                au_req.a = fct_reg;
                au_req.b = p1_reg;
            end
            nle_pkg::S_DDIV:
            begin
                au_req.op = nle_pkg::AOP_QDIV;
                au_req.a  = tmp_reg;
                au_req.b  = tmp2_reg;
            end
            nle_pkg::S_END:
            begin
                au_req.op = nle_pkg::AOP_ROOT;
                au_req.a  = 64'({deg_reg, 1'b1});
                au_req.b  = 64'sd1;
                au_req.sh = 6'(2 * nle_pkg::FRAC_BITS - 1);
            end
            nle_pkg::S_ENDM:
            begin
                au_req.op = nle_pkg::AOP_IMUL;
                au_req.a  = tmp_reg;
                au_req.b  = 64'(tri_n);
            end
            default:
                au_use = 1'b0;
        endcase
        au_req.start = au_use && !issued_reg;
        req_ready    = (state_reg == nle_pkg::S_IDLE);
        rsp_valid    = out_valid_reg;
        rsp          = out_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nle_pkg::S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
                issued_reg <= 1'b0;
            else if (au_req.start)
                issued_reg <= 1'b1;
            if (state_reg == nle_pkg::S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers: the request is captured in idle, the output word in the final state, most others on done
    always_ff @(posedge clk)
    begin
        case (state_reg)
            nle_pkg::S_IDLE:
                if (req_valid)
                begin
                    cmd_reg      <= req.cmd;
                    deg_reg      <= req.degree;
                    n_reg        <= {1'b0, req.degree};
                    m_reg        <= req.cmd ? 6'd0 : req.order;
                    phase_reg    <= 1'b0;
                    x_reg        <= x_clamped;
                    xneg_end_reg <= (x_clamped == -X_ONE) && !req.degree[0];
                    status_reg   <= (!req.cmd && req.order > req.degree) ? nle_pkg::ST_ORDER
                                                                         : nle_pkg::ST_OK;
                    res_reg      <= '0;
                end
            nle_pkg::S_OMX:
                if (done)
                begin
                    omx_reg <= den_val;
                    pmm_reg <= nle_pkg::ONE;
                    k_reg   <= 7'd1;
                end
            nle_pkg::S_SEED_M, nle_pkg::S_SEED_I:
                if (done)
                    pmm_reg <= au_rsp.result;
            nle_pkg::S_SEED_D:
                if (done)
                begin
                    pmm_reg <= au_rsp.result;
                    k_reg   <= k_reg + 7'd1;
                end
            nle_pkg::S_SEED_N, nle_pkg::S_P1A, nle_pkg::S_XP, nle_pkg::S_CO,
            nle_pkg::S_XN, nle_pkg::S_DA, nle_pkg::S_END:
                if (done)
                    tmp_reg <= au_rsp.result;
            nle_pkg::S_SEED_R:
                if (done)
                begin
                    pmm_reg <= seed_root;
                    res_reg <= seed_root;
                end
            nle_pkg::S_PREV:
                if (done)
                    prev_reg <= au_rsp.result;
            nle_pkg::S_P1B:
                if (done)
                begin
                    p1_reg  <= au_rsp.result;
                    res_reg <= au_rsp.result;
                    k_reg   <= m_plus2[6:0];
                end
            nle_pkg::S_FCT, nle_pkg::S_CO2:
                if (done)
                    fct_reg <= au_rsp.result;
            nle_pkg::S_QD:
                if (done)
                    tmp2_reg <= sat_sub(tmp_reg, au_rsp.result);
            nle_pkg::S_PK:
                if (done)
                begin
                    p1_reg   <= au_rsp.result;
                    res_reg  <= au_rsp.result;
                    pmm_reg  <= p1_reg;
                    prev_reg <= fct_reg;
                    k_reg    <= k_reg + 7'd1;
                end
            nle_pkg::S_LFIN:
                if (cmd_reg)
                begin
                    if (!phase_reg)
                    begin
                        pn_reg    <= res_reg;
                        phase_reg <= 1'b1;
                        n_reg     <= {1'b0, deg_reg} + 7'd1;
                    end
                    else
                        p1_reg <= res_reg;
                end
            nle_pkg::S_DB:
                if (done)
                    tmp_reg <= sat_sub(tmp_reg, au_rsp.result);
            nle_pkg::S_DEN:
                if (done)
                    tmp2_reg <= (den_val <= 64'sd0) ? 64'sd1 : den_val;
            nle_pkg::S_DDIV:
                if (done)
                    res_reg <= au_rsp.result;
            nle_pkg::S_ENDM:
                if (done)
                    res_reg <= xneg_end_reg ? -au_rsp.result : au_rsp.result;
            nle_pkg::S_FIN:
                if (out_free)
                begin
                    // clip to the 40-bit result range
                    if (res_reg > 64'(nle_pkg::OUT_MAX))
                    begin
                        out_word_reg.result_value <= nle_pkg::OUT_MAX;
                        out_word_reg.status       <= nle_pkg::ST_SAT;
                    end
                    else if (res_reg < 64'(nle_pkg::OUT_MIN))
                    begin
                        out_word_reg.result_value <= nle_pkg::OUT_MIN;
                        out_word_reg.status       <= nle_pkg::ST_SAT;
                    end
                    else
                    begin
                        out_word_reg.result_value <= res_reg[39:0];
                        out_word_reg.status       <= status_reg;
                    end
                end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/nle_arith.sv @@
`timescale 1ns / 1ps
// shared multi-cycle unit: fixed-point and integer multiply and divide, and root of a ratio
module nle_arith (
    input  logic             clk,
    input  logic             rst_n,
    input  nle_pkg::au_req_t req,
    output nle_pkg::au_rsp_t rsp
);

    localparam logic [127:0] HALF = 128'd1 << (nle_pkg::FRAC_BITS - 1);

    nle_pkg::au_state_t state_reg, state_next;
    nle_pkg::au_op_t    op_reg;
    logic               neg_reg;
    logic [63:0]        amag_reg, bmag_reg;
    logic [63:0]        pp_reg;
    logic [127:0]       acc_reg;
    logic [6:0]         cnt_reg;
    logic [95:0]        dvd_reg, quot_reg;
    logic [63:0]        dsr_reg, rem_reg;
    logic [47:0]        sq_root_reg;
    logic [51:0]        sq_rem_reg;
    logic signed [63:0] result_reg;

    logic [63:0]  a_mag, b_mag;
    logic [5:0]   shamt;
    logic [95:0]  dvd_start;
    logic [31:0]  pa, pb;
    logic [63:0]  pp_next;
    logic [127:0] pp_sh;
    logic [127:0] rnd;
    logic [63:0]  qm_mul, qm_div;
    logic [63:0]  r2;
    logic         dge;
    logic [51:0]  rem2, trial;
    logic         sge;

    // operand preparation
    always_comb
    begin
        a_mag = req.a[63] ? 64'(-req.a) : 64'(req.a);
        b_mag = req.b[63] ? 64'(-req.b) : 64'(req.b);
        case (req.op)
            nle_pkg::AOP_QDIV: shamt = 6'(nle_pkg::FRAC_BITS);
            nle_pkg::AOP_ROOT: shamt = req.sh;
            default:           shamt = 6'd0;
        endcase
        dvd_start = {32'b0, a_mag} << shamt;
    end

    // partial products, low halves first
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin pa = amag_reg[31:0];  pb = bmag_reg[31:0];  end
            2'd1:    begin pa = amag_reg[31:0];  pb = bmag_reg[63:32]; end
            2'd2:    begin pa = amag_reg[63:32]; pb = bmag_reg[31:0];  end
            default: begin pa = amag_reg[63:32]; pb = bmag_reg[63:32]; end
        endcase
        pp_next = 64'(pa) * 64'(pb);
        case (cnt_reg)
            7'd1:       pp_sh = {64'b0, pp_reg};
            7'd2, 7'd3: pp_sh = {32'b0, pp_reg, 32'b0};
            default:    pp_sh = {pp_reg, 64'b0};
        endcase
    end

    // rounding and clamping of results
    always_comb
    begin
        rnd = acc_reg + HALF;
        if (|rnd[127:64+nle_pkg::FRAC_BITS])
            qm_mul = 64'(nle_pkg::LIM);
        else if (rnd[63+nle_pkg::FRAC_BITS:nle_pkg::FRAC_BITS] > 64'(nle_pkg::LIM))
            qm_mul = 64'(nle_pkg::LIM);
        else
            qm_mul = rnd[63+nle_pkg::FRAC_BITS:nle_pkg::FRAC_BITS];
        qm_div = (quot_reg > 96'(nle_pkg::LIM)) ? 64'(nle_pkg::LIM) : quot_reg[63:0];
    end

    // one restoring divide bit and one root bit per cycle
    always_comb
    begin
        r2    = {rem_reg[62:0], dvd_reg[95]};
        dge   = (r2 >= dsr_reg);
        rem2  = {sq_rem_reg[49:0], dvd_reg[95:94]};
        trial = {2'b00, sq_root_reg, 2'b01};
        sge   = (rem2 >= trial);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nle_pkg::AU_IDLE:
                if (req.start)
                begin
                    if (req.op == nle_pkg::AOP_QMUL || req.op == nle_pkg::AOP_IMUL)
                        state_next = nle_pkg::AU_MUL;
                    else if (req.op == nle_pkg::AOP_QDIV && req.b <= 64'sd0)
                        state_next = nle_pkg::AU_DONE;
                    else
                        state_next = nle_pkg::AU_DIV;
                end
            nle_pkg::AU_MUL:
                if (cnt_reg == 7'(nle_pkg::MUL_STEPS))
                    state_next = nle_pkg::AU_MFIN;
            nle_pkg::AU_MFIN:
                state_next = nle_pkg::AU_DONE;
            nle_pkg::AU_DIV:
                if (cnt_reg == 7'(nle_pkg::DVD_W - 1))
                    state_next = nle_pkg::AU_DFIN;
            nle_pkg::AU_DFIN:
                state_next = (op_reg == nle_pkg::AOP_ROOT) ? nle_pkg::AU_SQRT
                                                           : nle_pkg::AU_DONE;
            nle_pkg::AU_SQRT:
                if (cnt_reg == 7'(nle_pkg::SQ_STEPS - 1))
                    state_next = nle_pkg::AU_DONE;
            nle_pkg::AU_DONE:
                state_next = nle_pkg::AU_IDLE;
            default:
                state_next = nle_pkg::AU_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done   = (state_reg == nle_pkg::AU_DONE);
        rsp.result = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nle_pkg::AU_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            nle_pkg::AU_IDLE:
                if (req.start)
                begin
                    op_reg   <= req.op;
                    amag_reg <= a_mag;
                    bmag_reg <= b_mag;
                    neg_reg  <= (req.op == nle_pkg::AOP_QDIV) ? req.a[63]
                                                              : (req.a[63] ^ req.b[63]);
                    acc_reg  <= '0;
                    cnt_reg  <= '0;
                    dvd_reg  <= dvd_start;
                    dsr_reg  <= 64'(req.b);
                    rem_reg  <= '0;
                    quot_reg <= '0;
                    result_reg <= req.a[63] ? -nle_pkg::LIM : nle_pkg::LIM;
                end
            nle_pkg::AU_MUL:
            begin
                if (cnt_reg < 7'(nle_pkg::MUL_STEPS))
                    pp_reg <= pp_next;
                if (cnt_reg != 7'd0)
                    acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 7'd1;
            end
            nle_pkg::AU_MFIN:
                if (op_reg == nle_pkg::AOP_QMUL)
                    result_reg <= neg_reg ? -qm_mul : qm_mul;
                else
                    result_reg <= neg_reg ? -acc_reg[63:0] : acc_reg[63:0];
            nle_pkg::AU_DIV:
            begin
                rem_reg  <= dge ? (r2 - dsr_reg) : r2;
                quot_reg <= {quot_reg[94:0], dge};
                dvd_reg  <= {dvd_reg[94:0], 1'b0};
                cnt_reg  <= cnt_reg + 7'd1;
            end
            nle_pkg::AU_DFIN:
            begin
                if (op_reg == nle_pkg::AOP_QDIV)
                    result_reg <= neg_reg ? -qm_div : qm_div;
                else
                    result_reg <= quot_reg[63:0];
                dvd_reg     <= quot_reg;
                sq_root_reg <= '0;
                sq_rem_reg  <= '0;
                cnt_reg     <= '0;
            end
            nle_pkg::AU_SQRT:
            begin
                sq_rem_reg  <= sge ? (rem2 - trial) : rem2;
                sq_root_reg <= {sq_root_reg[46:0], sge};
                dvd_reg     <= {dvd_reg[93:0], 2'b00};
                cnt_reg     <= cnt_reg + 7'd1;
                result_reg  <= {16'b0, sq_root_reg[46:0], sge};
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/nle_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the legendre evaluator, bound to the top level
module nle_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input nle_pkg::req_word_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input nle_pkg::rsp_word_t rsp
);

    // a stalled output word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("output word changed while stalled");

    // one word in flight: ready drops after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready stayed high after accept");

    a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == nle_pkg::ST_ORDER |-> rsp.result_value == '0)
        else $error("order error with nonzero value");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == nle_pkg::ST_SAT |->
            rsp.result_value == nle_pkg::OUT_MAX || rsp.result_value == nle_pkg::OUT_MIN)
        else $error("saturated status without bound value");

endmodule

bind normalized_legendre_evaluator_unit nle_checker u_nle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

@@ dv/tb_normalized_legendre_evaluator_unit.sv @@
`timescale 1ns / 1ps
// testbench: directed and random requests checked against a fixed-point legendre predictor
module tb_normalized_legendre_evaluator_unit;

    // number of random requests after the directed table
    localparam int N_RANDOM = 120;
    // requests from this index on run with no idling on either side
    localparam int CALM_FROM = 100;
    // random request at which the sender drains the block before going on
    localparam int DRAIN_AT = 20;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    nle_pkg::req_word_t req;
    logic               rsp_valid;
    logic               rsp_ready;
    nle_pkg::rsp_word_t rsp;

    // expected response words in request order
    nle_pkg::rsp_word_t expected_rsp_q[$];
    int                 error_count;
    bit                 calm_phase;

    typedef struct {
        nle_pkg::req_word_t w;
        bit                 typed;
        nle_pkg::rsp_word_t r;
    } stim_row_t;

    stim_row_t directed_rows[$];

    normalized_legendre_evaluator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------------------------------------------------------
    // fixed-point predictor, 64-bit words with FRAC_BITS fraction bits
    // ---------------------------------------------------------------

    function automatic logic [63:0] magnitude(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    // clamp of an unsigned wide value to the intermediate limit
    function automatic longint clamp_wide(logic [127:0] w);
        if (w > 128'(nle_pkg::LIM))
            return nle_pkg::LIM;
        return longint'(w[63:0]);
    endfunction

    function automatic longint clamp_lim(longint v);
        if (v > nle_pkg::LIM)
            return nle_pkg::LIM;
        if (v < -nle_pkg::LIM)
            return -nle_pkg::LIM;
        return v;
    endfunction

    // product rounded to nearest on the magnitude, ties away from zero
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        logic [63:0]  m;
        bit           neg;
        neg = (a < 0) != (b < 0);
        p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
        p = p + (128'd1 << (nle_pkg::FRAC_BITS - 1));
        if ((p >> (64 + nle_pkg::FRAC_BITS)) != 0)
            m = nle_pkg::LIM;
        else
            m = 64'(p >> nle_pkg::FRAC_BITS);
        if (m > nle_pkg::LIM)
            m = nle_pkg::LIM;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // quotient truncated toward zero
    function automatic longint fx_div(longint a, longint b);
        longint m;
        if (b <= 0)
            return (a < 0) ? -nle_pkg::LIM : nle_pkg::LIM;
        m = clamp_wide(({64'b0, magnitude(a)} << nle_pkg::FRAC_BITS) / {64'b0, 64'(b)});
        return (a < 0) ? -m : m;
    endfunction

    // floor of sqrt((num << s) / den), clamped
    function automatic longint root_of_ratio(logic [63:0] num, int s, logic [63:0] den);
        logic [127:0] v;
        logic [63:0]  r;
        logic [63:0]  t;
        v = ({64'b0, num} << s) / {64'b0, den};
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'b0, t} * {64'b0, t} <= v)
                r = t;
        end
        return clamp_wide({64'b0, r});
    endfunction

    // seed product over m, then upward recurrence in n
    function automatic longint legendre_value(longint n, longint m, longint x);
        longint omx;
        longint pmm;
        longint p1;
        longint prev;
        longint fct;
        longint pk;
        omx = nle_pkg::ONE - fx_mul(x, x);
        pmm = nle_pkg::ONE;
        for (longint i = 1; i <= m; i++)
        begin
            pmm = fx_mul(pmm, omx);
            pmm = pmm * (2 * i - 1) / (2 * i);
        end
        pmm = root_of_ratio(64'(pmm) * 64'(2 * m + 1), nle_pkg::FRAC_BITS, 64'd2);
        if (m % 2 == 1)
            pmm = -pmm;
        if (n == m)
            return pmm;
        prev = root_of_ratio(64'(2 * m + 3), 2 * nle_pkg::FRAC_BITS, 64'd1);
        p1 = fx_mul(fx_mul(x, prev), pmm);
        for (longint k = m + 2; k <= n; k++)
        begin
            fct = root_of_ratio(64'(4 * k * k - 1), 2 * nle_pkg::FRAC_BITS,
                                64'(k * k - m * m));
            pk = fx_mul(clamp_lim(fx_mul(x, p1) - fx_div(pmm, prev)), fct);
            prev = fct;
            pmm = p1;
            p1 = pk;
        end
        return p1;
    endfunction

    function automatic longint legendre_slope(longint n, longint x);
        longint c;
        longint pn;
        longint pn1;
        longint coeff;
        longint num;
        longint den;
        // endpoints use the closed form, sign follows the parity of n at x = -1
        if (x >= nle_pkg::ONE || x <= -nle_pkg::ONE)
        begin
            c = root_of_ratio(64'(2 * n + 1), 2 * nle_pkg::FRAC_BITS - 1, 64'd1)
                * (n * (n + 1) / 2);
            c = clamp_lim(c);
            if (x <= -nle_pkg::ONE && n % 2 == 0)
                c = -c;
            return c;
        end
        pn = legendre_value(n, 0, x);
        pn1 = legendre_value(n + 1, 0, x);
        coeff = root_of_ratio(64'(2 * n + 1), 2 * nle_pkg::FRAC_BITS, 64'(2 * n + 3))
                * (n + 1);
        num = clamp_lim(fx_mul(x * (n + 1), pn) - fx_mul(coeff, pn1));
        den = nle_pkg::ONE - fx_mul(x, x);
        if (den <= 0)
            den = 1;
        return fx_div(num, den);
    endfunction

    function automatic nle_pkg::rsp_word_t predict_legendre(nle_pkg::req_word_t w);
        nle_pkg::rsp_word_t o;
        longint             x;
        longint             r;
        x = longint'(w.x_value);
        if (x > nle_pkg::ONE)
            x = nle_pkg::ONE;
        if (x < -nle_pkg::ONE)
            x = -nle_pkg::ONE;
        o.status = nle_pkg::ST_OK;
        if (w.cmd)
            r = legendre_slope(longint'(w.degree), x);
        else if (w.order > w.degree)
        begin
            r = 0;
            o.status = nle_pkg::ST_ORDER;
        end
        else
            r = legendre_value(longint'(w.degree), longint'(w.order), x);
        if (r > longint'(nle_pkg::OUT_MAX))
        begin
            r = nle_pkg::OUT_MAX;
            o.status = nle_pkg::ST_SAT;
        end
        if (r < longint'(nle_pkg::OUT_MIN))
        begin
            r = nle_pkg::OUT_MIN;
            o.status = nle_pkg::ST_SAT;
        end
        o.result_value = r[39:0];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic nle_pkg::req_word_t make_req(logic c, int n, int m,
                                                    logic signed [31:0] x);
        nle_pkg::req_word_t w;
        w.cmd = c;
        w.degree = 6'(n);
        w.order = 6'(m);
        w.x_value = x;
        return w;
    endfunction

    function automatic void add_row(nle_pkg::req_word_t w, bit typed,
                                    nle_pkg::rsp_word_t r);
        stim_row_t row;
        row.w = w;
        row.typed = typed;
        row.r = r;
        directed_rows.push_back(row);
    endfunction

    function automatic nle_pkg::req_word_t random_req();
        nle_pkg::req_word_t w;
        int                 pick;
        w.cmd = ($urandom_range(0, 3) == 0);
        // mostly low degrees keep the run short, a few go to the top
        if ($urandom_range(0, 9) == 0)
            w.degree = 6'($urandom_range(0, 63));
        else
            w.degree = 6'($urandom_range(0, 12));
        if ($urandom_range(0, 9) == 0)
            w.order = 6'($urandom_range(0, 63));
        else
            w.order = 6'($urandom_range(0, w.degree));
        pick = $urandom_range(0, 9);
        if (pick < 8)
            w.x_value = 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
        else if (pick == 8)
            w.x_value = ($urandom_range(0, 1) != 0) ? 32'sd1073741824 : -32'sd1073741824;
        else
            w.x_value = 32'($urandom());
        return w;
    endfunction

    // hands one word to the block, with an optional idle burst first
    task automatic send_word(nle_pkg::req_word_t w, bit typed, nle_pkg::rsp_word_t r);
        if (!calm_phase && $urandom_range(0, 2) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        expected_rsp_q.push_back(typed ? r : predict_legendre(w));
    endtask

    // response ready: random stall bursts, none in the calm phase
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm_phase)
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected word value=%h status=%0d", $time,
                         rsp.result_value, rsp.status);
                error_count++;
            end
            else
            begin
                nle_pkg::rsp_word_t e;
                e = expected_rsp_q.pop_front();
                if (rsp.result_value !== e.result_value)
                begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             e.result_value, rsp.result_value);
                    error_count++;
                end
                if (rsp.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, rsp.status);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        nle_pkg::rsp_word_t zero_order;
        nle_pkg::rsp_word_t none;
        nle_pkg::rsp_word_t sat_hi;
        nle_pkg::rsp_word_t sat_lo;
        error_count = 0;
        calm_phase = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        zero_order.result_value = '0;
        zero_order.status = nle_pkg::ST_ORDER;
        none = '0;
        sat_hi.result_value = nle_pkg::OUT_MAX;
        sat_hi.status = nle_pkg::ST_SAT;
        sat_lo.result_value = nle_pkg::OUT_MIN;
        sat_lo.status = nle_pkg::ST_SAT;

        // order above degree gives a zero word with the order status
        add_row(make_req(1'b0, 0, 1, 32'sd0), 1'b1, zero_order);
        add_row(make_req(1'b0, 62, 63, 32'sd1073741824), 1'b1, zero_order);
        add_row(make_req(1'b0, 0, 63, -32'sd1073741824), 1'b1, zero_order);
        // the endpoint slope at the top two degrees saturates; at x = -1 even n flips sign
        add_row(make_req(1'b1, 63, 0, 32'sd1073741824), 1'b1, sat_hi);
        add_row(make_req(1'b1, 62, 0, -32'sd1073741824), 1'b1, sat_lo);
        add_row(make_req(1'b1, 63, 5, -32'sd1073741824), 1'b1, sat_hi);
        // low degrees and orders
        add_row(make_req(1'b0, 0, 0, 32'sd0), 1'b0, none);
        add_row(make_req(1'b0, 1, 0, 32'sd536870912), 1'b0, none);
        add_row(make_req(1'b0, 1, 1, -32'sd536870912), 1'b0, none);
        add_row(make_req(1'b0, 5, 3, 32'sd1073741824), 1'b0, none);
        add_row(make_req(1'b0, 4, 4, -32'sd1073741824), 1'b0, none);
        // x outside [-1,1] is clamped
        add_row(make_req(1'b0, 3, 1, 32'sh7FFF_FFFF), 1'b0, none);
        add_row(make_req(1'b0, 3, 2, 32'sh8000_0000), 1'b0, none);
        add_row(make_req(1'b1, 2, 0, 32'sh7FFF_FFFF), 1'b0, none);
        add_row(make_req(1'b1, 3, 0, 32'sh8000_0000), 1'b0, none);
        // derivative inside the interval, order ignored
        add_row(make_req(1'b1, 0, 63, 32'sd0), 1'b0, none);
        add_row(make_req(1'b1, 4, 0, -32'sd268435456), 1'b0, none);
        add_row(make_req(1'b1, 1, 2, 32'sd1073741823), 1'b0, none);
        // top degree and order, one value near each endpoint
        add_row(make_req(1'b0, 63, 63, 32'sd1000), 1'b0, none);
        add_row(make_req(1'b0, 63, 0, 32'sd1073741823), 1'b0, none);
        add_row(make_req(1'b0, 63, 62, -32'sd1073741823), 1'b0, none);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == DRAIN_AT)
            begin
                req_valid <= 1'b0;
                while (expected_rsp_q.size() != 0)
                    @(posedge clk);
            end
            if (i == CALM_FROM)
                calm_phase = 1'b1;
            send_word(random_req(), 1'b0, none);
        end
        req_valid <= 1'b0;

        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // overall time limit
    initial
    begin
        #400_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
